>>> rtl/core/qkl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qkl_pkg: shared types, constants and helpers of the query keyword lexer
// Store geometry, token kind codes, character classes and keyword spelling.
// ----------------------------------------------------------------------------
package qkl_pkg;

  localparam int WORD_BUFFER_SIZE = 32;
  localparam int STORE_CAP        = WORD_BUFFER_SIZE - 1;
  localparam int LEN_W            = $clog2(STORE_CAP + 1);
  localparam int ADDR_W           = $clog2(STORE_CAP);

  localparam logic [LEN_W-1:0] STORE_FULL = LEN_W'(STORE_CAP);
  localparam logic [LEN_W-1:0] SELECT_LEN = LEN_W'(6);
  localparam logic [LEN_W-1:0] FROM_LEN   = LEN_W'(4);

  typedef enum logic [2:0] {
    KIND_SELECT   = 3'd0,
    KIND_FROM     = 3'd1,
    KIND_IDCHAR   = 3'd2,
    KIND_ASTERISK = 3'd3,
    KIND_COMMA    = 3'd4
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AST   = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // word store access, one write and one registered read per cycle
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "a" && c <= "z") r = c - 8'h20;
    return r;
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // uppercase spelling of SELECT (sel_select) or FROM at position idx
  function automatic logic [7:0] kw_char(input logic sel_select,
                                         input logic [ADDR_W-1:0] idx);
    logic [7:0] r;
    r = CH_NUL;
    if (sel_select) begin
      case (idx)
        ADDR_W'(0): r = "S";
        ADDR_W'(1): r = "E";
        ADDR_W'(2): r = "L";
        ADDR_W'(3): r = "E";
        ADDR_W'(4): r = "C";
        ADDR_W'(5): r = "T";
        default:    r = CH_NUL;
      endcase
    end else begin
      case (idx)
        ADDR_W'(0): r = "F";
        ADDR_W'(1): r = "R";
        ADDR_W'(2): r = "O";
        ADDR_W'(3): r = "M";
        default:    r = CH_NUL;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/qkl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qkl_if: valid/ready channels of the query keyword lexer
// Text byte input channel and token output channel.
// ----------------------------------------------------------------------------
interface qkl_in_if import qkl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface qkl_out_if import qkl_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] word_char;
  logic       word_end;
  logic       word_truncated;
  logic       last;

  modport source (output valid, output kind, output word_char, output word_end,
                  output word_truncated, output last, input ready);
  modport sink   (input valid, input kind, input word_char, input word_end,
                  input word_truncated, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/qkl_word_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qkl_word_store: character store of the pending word
// One write port, one read port with registered data held between reads.
// ----------------------------------------------------------------------------
module qkl_word_store import qkl_pkg::*; (
  input  wire logic       clk,
  input  wire store_req_t req,
  output logic [7:0]      rd_data
);

  logic [7:0] mem [STORE_CAP];

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) rd_data <= mem[req.rd_addr];
  end

endmodule
`default_nettype wire

>>> rtl/core/query_keyword_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// query_keyword_lexer: byte-wide lexer for SELECT / FROM query text
// Splits ASCII text into keyword, identifier-character and punctuation tokens.
// ----------------------------------------------------------------------------
// Usage: feed one text byte per beat on text; end_of_text marks the final byte
// of a query. Letters and digits collect in a 31-entry word store (more are
// dropped and the word is flagged truncated). Whitespace, '*', ',', NUL or
// end_of_text close the pending word: SELECT or FROM (any case, untruncated)
// give one keyword token, any other word gives one token per stored character
// with word_end on the final one. A '*' or ',' token follows the word. Other
// bytes are ignored. After NUL the rest of the query is ignored until
// end_of_text. last marks the final token caused by a byte.
// Timing: a byte that closes no word is accepted in S_IDLE. Closing a word of
// n characters runs a sequencer around the store's single read port and one
// shared byte comparator: keyword candidates (length 4 or 6) are checked by a
// read and a compare per character, then each identifier character is read
// and sent as a token beat, a keyword as its keyword beat, then punctuation
// as its own beat. Output stalls hold the beat; text is not ready meanwhile.
// ----------------------------------------------------------------------------
module query_keyword_lexer import qkl_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  qkl_in_if.sink     text,
  qkl_out_if.source  token
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,  // issue store read at idx
    S_CHECK = 6'b000100,  // compare read char against keyword spelling
    S_CHAR  = 6'b001000,  // identifier character beat
    S_KEYW  = 6'b010000,  // keyword beat
    S_PUNCT = 6'b100000   // asterisk / comma beat
  } state_t;

  state_t            state, state_next;
  logic [LEN_W-1:0]  len, len_next;
  logic              trunc, trunc_next;
  logic              halted, halted_next;
  logic              punct_pend, punct_pend_next;
  kind_t             punct_kind, punct_kind_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic              matching, matching_next;
  logic              kw_sel, kw_sel_next;

  store_req_t        store_req;
  logic [7:0]        rd_data;

  logic              accept, out_done;
  logic              live, wc, nul, blank, ast, com, ends, room;
  logic [LEN_W-1:0]  len_upd;
  logic              trunc_upd;
  logic              idx_last;

  qkl_word_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (rd_data)
  );

  // byte classification, only while not parked after NUL
  assign accept    = text.valid && text.ready;
  assign out_done  = token.valid && token.ready;
  assign live      = !halted;
  assign wc        = live && is_word_char(text.text_byte);
  assign nul       = live && (text.text_byte == CH_NUL);
  assign blank     = live && is_blank(text.text_byte);
  assign ast       = live && (text.text_byte == CH_AST);
  assign com       = live && (text.text_byte == CH_COMMA);
  assign ends      = nul || blank || ast || com || text.end_of_text;
  assign room      = len < STORE_FULL;
  assign len_upd   = (wc && room) ? len + LEN_W'(1) : len;
  assign trunc_upd = trunc || (wc && !room);
  assign idx_last  = (LEN_W'(idx) + LEN_W'(1)) == len;

  assign store_req.wr_en   = accept && wc && room;
  assign store_req.wr_addr = len[ADDR_W-1:0];
  assign store_req.wr_data = text.text_byte;
  assign store_req.rd_en   = (state == S_FETCH);
  assign store_req.rd_addr = idx;

  assign text.ready = (state == S_IDLE);

  // token payload straight from sequencer state and the store's read register
  always_comb begin
    token.valid          = 1'b0;
    token.kind           = KIND_IDCHAR;
    token.word_char      = CH_NUL;
    token.word_end       = 1'b0;
    token.word_truncated = 1'b0;
    token.last           = 1'b0;
    unique case (state)
      S_CHAR: begin
        token.valid          = 1'b1;
        token.kind           = KIND_IDCHAR;
        token.word_char      = rd_data;
        token.word_end       = idx_last;
        token.word_truncated = trunc;
        token.last           = idx_last && !punct_pend;
      end
      S_KEYW: begin
        token.valid = 1'b1;
        token.kind  = kw_sel ? KIND_SELECT : KIND_FROM;
        token.last  = !punct_pend;
      end
      S_PUNCT: begin
        token.valid = 1'b1;
        token.kind  = punct_kind;
        token.last  = 1'b1;
      end
      default: begin
        token.valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    len_next        = len;
    trunc_next      = trunc;
    halted_next     = halted;
    punct_pend_next = punct_pend;
    punct_kind_next = punct_kind;
    idx_next        = idx;
    matching_next   = matching;
    kw_sel_next     = kw_sel;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          len_next   = len_upd;
          trunc_next = trunc_upd;
          if (text.end_of_text) halted_next = 1'b0;
          else if (nul)         halted_next = 1'b1;
          if (ends) begin
            punct_pend_next = ast || com;
            punct_kind_next = ast ? KIND_ASTERISK : KIND_COMMA;
            if (len_upd != '0) begin
              idx_next      = '0;
              matching_next = !trunc_upd &&
                              (len_upd == SELECT_LEN || len_upd == FROM_LEN);
              kw_sel_next   = (len_upd == SELECT_LEN);
              state_next    = S_FETCH;
            end else begin
              len_next   = '0;
              trunc_next = 1'b0;
              state_next = (ast || com) ? S_PUNCT : S_IDLE;
            end
          end
        end
      end
      S_FETCH: begin
        state_next = matching ? S_CHECK : S_CHAR;
      end
      S_CHECK: begin
        if (to_upper(rd_data) != kw_char(kw_sel, idx)) begin
          matching_next = 1'b0;
          idx_next      = '0;
          state_next    = S_FETCH;
        end else if (idx_last) begin
          state_next = S_KEYW;
        end else begin
          idx_next   = idx + ADDR_W'(1);
          state_next = S_FETCH;
        end
      end
      S_CHAR: begin
        if (out_done) begin
          if (idx_last) begin
            len_next   = '0;
            trunc_next = 1'b0;
            state_next = punct_pend ? S_PUNCT : S_IDLE;
          end else begin
            idx_next   = idx + ADDR_W'(1);
            state_next = S_FETCH;
          end
        end
      end
      S_KEYW: begin
        if (out_done) begin
          len_next   = '0;
          trunc_next = 1'b0;
          state_next = punct_pend ? S_PUNCT : S_IDLE;
        end
      end
      S_PUNCT: begin
        if (out_done) begin
          punct_pend_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      len        <= '0;
      trunc      <= 1'b0;
      halted     <= 1'b0;
      punct_pend <= 1'b0;
      matching   <= 1'b0;
    end else begin
      state      <= state_next;
      len        <= len_next;
      trunc      <= trunc_next;
      halted     <= halted_next;
      punct_pend <= punct_pend_next;
      matching   <= matching_next;
    end
  end

  always_ff @(posedge clk) begin
    punct_kind <= punct_kind_next;
    idx        <= idx_next;
    kw_sel     <= kw_sel_next;
  end

  // parked after NUL means the word was already flushed
  a_halted_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && halted) |-> (len == '0))
    else $error("halted with a pending word");

  // keyword compare only runs on untruncated words of keyword length
  a_check_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (!trunc && (len == SELECT_LEN || len == FROM_LEN)))
    else $error("keyword compare on non-candidate word");

  // every read of the store stays inside the written part of the word
  a_read_in_word: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (LEN_W'(idx) < len))
    else $error("store read beyond word length");

  // read data is consumed right after the read is issued
  a_fetch_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |=> (state == S_CHECK || state == S_CHAR))
    else $error("store read not followed by use");

  // end of text always leaves the lexer unparked
  a_eot_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && text.end_of_text) |=> !halted)
    else $error("still halted after end of text");

endmodule
`default_nettype wire
